// ===== sv/rkst_pkg.sv =====
// ----------------------------------------------------------------------------
// rkst_pkg
// Shared types and constants for the reference-counted key/slot table.
// ----------------------------------------------------------------------------
package rkst_pkg;

   localparam int MAX_ENTRIES = 16;
   localparam int SLOT_W      = 4;
   localparam int CNT_W       = 16;
   localparam int ACTIVE_W    = 5;
   localparam int KEY_W       = 32;
   localparam int NAME_W      = 32;
   localparam int DIM_W       = 16;

   localparam logic [1:0] CMD_ACQUIRE = 2'd0;
   localparam logic [1:0] CMD_RELEASE = 2'd1;
   localparam logic [1:0] CMD_BIND    = 2'd2;
   localparam logic [1:0] CMD_READ    = 2'd3;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_FULL    = 2'd1;
   localparam logic [1:0] STATUS_INVALID = 2'd2;

   typedef struct packed {
      logic [1:0]        command;
      logic [KEY_W-1:0]  key_hash;
      logic [SLOT_W-1:0] slot_index;
      logic [NAME_W-1:0] handle_name;
      logic [DIM_W-1:0]  item_width;
      logic [DIM_W-1:0]  item_height;
   } req_type;

   typedef struct packed {
      logic [SLOT_W-1:0] result_slot;
      logic              was_hit;
      logic [1:0]        status;
      logic [CNT_W-1:0]  count_after;
      logic              was_freed;
      logic [NAME_W-1:0] entry_name;
      logic [DIM_W-1:0]  entry_width;
      logic [DIM_W-1:0]  entry_height;
      logic              bind_needed;
   } rsp_type;

   typedef struct packed {
      logic [KEY_W-1:0]  key;
      logic [NAME_W-1:0] handle;
      logic [DIM_W-1:0]  width;
      logic [DIM_W-1:0]  height;
   } payload_type;

   typedef struct packed {
      logic [CNT_W-1:0] count;
      payload_type      payload;
   } slot_type;

   typedef struct packed {
      logic              count_en;
      logic              payload_en;
      logic [SLOT_W-1:0] addr;
      logic [CNT_W-1:0]  count;
      payload_type       payload;
   } slot_wr_type;

endpackage

// ===== sv/rkst_slot_store.sv =====
// ----------------------------------------------------------------------------
// rkst_slot_store
// Slot storage: retain counts in reset flops, payload in plain storage.
// A slot whose count is zero reads back as an all-zero payload.
// ----------------------------------------------------------------------------
module rkst_slot_store import rkst_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic [SLOT_W-1:0] rd_addr,
   input  slot_wr_type       wr,
   output slot_type          slot
);

   logic [CNT_W-1:0] count_ff [MAX_ENTRIES];
   payload_type      payload_ff [MAX_ENTRIES];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_ENTRIES; i++) begin
            count_ff[i] <= '0;
         end
      end else if (wr.count_en) begin
         count_ff[wr.addr] <= wr.count;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.payload_en) begin
         payload_ff[wr.addr] <= wr.payload;
      end
   end

   always_comb begin
      slot.count = count_ff[rd_addr];
      // free slots read as zero, whatever the payload storage holds
      slot.payload = (count_ff[rd_addr] != '0) ? payload_ff[rd_addr] : '0;
   end

endmodule

// ===== sv/refcounted_key_slot_table_top.sv =====
// ----------------------------------------------------------------------------
// refcounted_key_slot_table_top
// Reference-counted key/slot table with acquire, release, bind and read.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low. Release, bind and
// read go from idle through the exec state to a registered rsp_valid. Acquire
// walks the usable slots (active_entries, capped at 16) one per cycle through
// a single key compare and count unit: a hit ends the walk at that slot, a
// miss or a full table answers after the last usable slot. busy stays high
// until the result strobe, except for an acquire with no usable slot, which
// answers full in the cycle after start without raising busy; strobes can then
// come back to back. The result is on rsp_item for the single cycle that
// rsp_valid is high and cannot be held off; capture it then. A new command
// may start in the same cycle as the strobe. Write csr_wdata (active_entries)
// only while idle.
// ----------------------------------------------------------------------------
module refcounted_key_slot_table_top import rkst_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  req_type             req_item,
   output logic                rsp_valid,
   output rsp_type             rsp_item,
   input  logic                csr_we,
   input  logic [ACTIVE_W-1:0] csr_wdata
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_EXEC = 2'd2;

   localparam logic [ACTIVE_W-1:0] MAX_USABLE = ACTIVE_W'(MAX_ENTRIES);

   logic [1:0]          state_ff, state_in;
   req_type             req_ff, req_in;
   logic [SLOT_W-1:0]   scan_ff, scan_in;
   logic                free_found_ff, free_found_in;
   logic [SLOT_W-1:0]   free_idx_ff, free_idx_in;
   logic [NAME_W-1:0]   bound_ff, bound_in;
   logic [ACTIVE_W-1:0] active_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_ff, rsp_in;

   logic [ACTIVE_W-1:0] usable;
   logic [SLOT_W-1:0]   rd_addr;
   logic [SLOT_W-1:0]   claim_idx;
   logic [CNT_W-1:0]    count_dec;
   logic                live;
   logic                last;
   logic                invalid;
   slot_type            slot;
   slot_wr_type         wr;

   rkst_slot_store u_store (
      .clock   (clock),
      .reset   (reset),
      .rd_addr (rd_addr),
      .wr      (wr),
      .slot    (slot)
   );

   assign usable    = (active_ff > MAX_USABLE) ? MAX_USABLE : active_ff;
   assign rd_addr   = (state_ff == ST_SCAN) ? scan_ff : req_ff.slot_index;
   assign live      = (slot.count != '0);
   assign last      = ({1'b0, scan_ff} == (usable - ACTIVE_W'(1)));
   assign invalid   = ({1'b0, req_ff.slot_index} >= usable);
   assign claim_idx = free_found_ff ? free_idx_ff : scan_ff;
   assign count_dec = slot.count - CNT_W'(1);

   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      scan_in       = scan_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      bound_in      = bound_ff;
      rsp_valid_in  = 1'b0;
      rsp_in        = rsp_ff;
      wr            = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               req_in        = req_item;
               scan_in       = '0;
               free_found_in = 1'b0;
               if (req_item.command == CMD_ACQUIRE) begin
                  if (usable == '0) begin
                     // no usable slot at all: report full right away
                     rsp_in        = '0;
                     rsp_in.status = STATUS_FULL;
                     rsp_valid_in  = 1'b1;
                  end else begin
                     state_in = ST_SCAN;
                  end
               end else begin
                  state_in = ST_EXEC;
               end
            end
         end

         ST_SCAN: begin
            if (live && slot.payload.key == req_ff.key_hash) begin
               wr.count_en        = 1'b1;
               wr.addr            = scan_ff;
               wr.count           = (slot.count == '1) ? slot.count
                                                      : slot.count + CNT_W'(1);
               rsp_in             = '0;
               rsp_in.result_slot = scan_ff;
               rsp_in.was_hit     = 1'b1;
               rsp_in.count_after = wr.count;
               rsp_valid_in       = 1'b1;
               state_in           = ST_IDLE;
            end else begin
               // remember the lowest free slot while looking for a hit
               if (!live && !free_found_ff) begin
                  free_found_in = 1'b1;
                  free_idx_in   = scan_ff;
               end
               if (last) begin
                  rsp_in = '0;
                  if (free_found_ff || !live) begin
                     wr.count_en        = 1'b1;
                     wr.payload_en      = 1'b1;
                     wr.addr            = claim_idx;
                     wr.count           = CNT_W'(1);
                     wr.payload.key     = req_ff.key_hash;
                     wr.payload.handle  = req_ff.handle_name;
                     wr.payload.width   = req_ff.item_width;
                     wr.payload.height  = req_ff.item_height;
                     bound_in           = req_ff.handle_name;
                     rsp_in.result_slot = claim_idx;
                     rsp_in.count_after = CNT_W'(1);
                  end else begin
                     rsp_in.status = STATUS_FULL;
                  end
                  rsp_valid_in = 1'b1;
                  state_in     = ST_IDLE;
               end else begin
                  scan_in = scan_ff + SLOT_W'(1);
               end
            end
         end

         ST_EXEC: begin
            rsp_in       = '0;
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
            unique case (req_ff.command)
               CMD_RELEASE: begin
                  rsp_in.result_slot = req_ff.slot_index;
                  if (invalid) begin
                     rsp_in.status = STATUS_INVALID;
                  end else if (live) begin
                     wr.count_en        = 1'b1;
                     wr.addr            = req_ff.slot_index;
                     wr.count           = count_dec;
                     rsp_in.count_after = count_dec;
                     if (count_dec == '0) begin
                        rsp_in.was_freed  = 1'b1;
                        rsp_in.entry_name = slot.payload.handle;
                        if (bound_ff == slot.payload.handle) begin
                           bound_in = '0;
                        end
                     end
                  end
               end
               CMD_BIND: begin
                  rsp_in.bind_needed = (req_ff.handle_name != bound_ff);
                  bound_in           = req_ff.handle_name;
               end
               CMD_READ: begin
                  rsp_in.result_slot = req_ff.slot_index;
                  if (invalid) begin
                     rsp_in.status = STATUS_INVALID;
                  end else begin
                     rsp_in.count_after  = slot.count;
                     rsp_in.entry_name   = slot.payload.handle;
                     rsp_in.entry_width  = slot.payload.width;
                     rsp_in.entry_height = slot.payload.height;
                  end
               end
               CMD_ACQUIRE: begin
                  // acquire never reaches exec; drop without result
                  rsp_valid_in = 1'b0;
               end
            endcase
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         free_found_ff <= 1'b0;
         bound_ff      <= '0;
         active_ff     <= MAX_USABLE;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         free_found_ff <= free_found_in;
         bound_ff      <= bound_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_we) begin
            active_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      scan_ff     <= scan_in;
      free_idx_ff <= free_idx_in;
      rsp_ff      <= rsp_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

// ===== sv/rkst_checker.sv =====
// ----------------------------------------------------------------------------
// rkst_checker
// Port-level checks for the key/slot table, bound to the top level.
// ----------------------------------------------------------------------------
module rkst_checker import rkst_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input logic    rsp_valid,
   input rsp_type rsp_item
);

   // a strobe follows a busy cycle, or the start of an acquire with no usable slot
   a_strobe_after_cmd: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy || start))
      else $error("result strobe without a command");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_valid))
      else $error("accepted command neither busy nor answered");

   a_idle_on_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result shown while still busy");

   a_busy_ends_with_result: assert property (@(posedge clock) disable iff (reset)
      ($fell(busy) && !$past(reset)) |-> rsp_valid)
      else $error("busy dropped without a result");

   a_full_is_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.status == STATUS_FULL) |->
         (rsp_item.result_slot == '0 && !rsp_item.was_hit
          && rsp_item.count_after == '0))
      else $error("full result carries slot data");

endmodule

bind refcounted_key_slot_table_top rkst_checker u_rkst_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_item  (rsp_item)
);
